/* src/omv_pkg.sv */
// omv_pkg: shared types and constants for the online mean and variance core
// no dependencies; used by every module under src

package omv_pkg;

	localparam int SAMPLE_WIDTH_DEF = 32;
	localparam int COUNT_WIDTH_DEF  = 32;
	localparam int IO_W             = 32;
	localparam int SUM_W            = 63;
	localparam int DIV_CNT_W        = 6;

	typedef struct packed {
		logic busy;
		logic done;
	} omv_unit_stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV_MEAN,
		ST_RESID,
		ST_MUL,
		ST_ACC,
		ST_VAR,
		ST_DIV_VAR,
		ST_DONE
	} omv_state_t;

endpackage

/* src/omv_div.sv */
// omv_div: bit-serial restoring divider, one quotient bit per cycle
// dividend is taken from its top bit down; depends on omv_pkg

module omv_div #(
	parameter int COUNT_WIDTH = omv_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [omv_pkg::DIV_CNT_W-1:0] iters,
	input  logic [omv_pkg::SUM_W-1:0]     dividend,
	input  logic [COUNT_WIDTH-1:0]        divisor,
	output logic [omv_pkg::SUM_W-1:0]     quotient,
	output omv_pkg::omv_unit_stat_t       stat
);

	localparam int CW = COUNT_WIDTH;
	localparam int DW = omv_pkg::SUM_W;

	logic                          busy_q;
	logic                          done_q;
	logic [omv_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [CW-1:0]                 rem_q;
	logic [CW-1:0]                 dsr_q;
	logic [DW-1:0]                 dvd_q;
	logic [DW-1:0]                 quo_q;

	logic [CW:0]   shifted;
	logic [CW+1:0] diff;
	logic          fits;

	always_comb begin
		shifted = {rem_q, dvd_q[DW-1]};
		diff    = {1'b0, shifted} - {2'b00, dsr_q};
		fits    = ~diff[CW+1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= iters;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == omv_pkg::DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			dsr_q <= divisor;
			dvd_q <= dividend;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? diff[CW-1:0] : shifted[CW-1:0];
			dvd_q <= {dvd_q[DW-2:0], 1'b0};
			quo_q <= {quo_q[DW-2:0], fits};
		end
	end

	assign quotient  = quo_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* src/omv_mul.sv */
// omv_mul: shift-add multiplier, one multiplier bit per cycle
// unsigned operands; depends on omv_pkg

module omv_mul #(
	parameter int SAMPLE_WIDTH = omv_pkg::SAMPLE_WIDTH_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      start,
	input  logic [SAMPLE_WIDTH-1:0]   mcand,
	input  logic [SAMPLE_WIDTH-1:0]   mplier,
	output logic [2*SAMPLE_WIDTH-1:0] prod,
	output omv_pkg::omv_unit_stat_t   stat
);

	localparam int SW  = SAMPLE_WIDTH;
	localparam int CNW = $clog2(SW + 1);

	logic           busy_q;
	logic           done_q;
	logic [CNW-1:0] cnt_q;
	logic [SW-1:0]  mc_q;
	logic [2*SW-1:0] acc_q;
	logic [SW:0]    part;

	always_comb begin
		part = {1'b0, acc_q[2*SW-1:SW]} + (acc_q[0] ? {1'b0, mc_q} : '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNW'(SW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mc_q  <= mcand;
			acc_q <= {{SW{1'b0}}, mplier};
		end else if (busy_q) begin
			acc_q <= {part, acc_q[SW-1:1]};
		end
	end

	assign prod      = acc_q;
	assign stat.busy = busy_q;
	assign stat.done = done_q;

endmodule

/* src/online_mean_variance_core.sv */
// online_mean_variance_core: Welford running count, mean, squared-deviation sum and variance
// uses omv_pkg, omv_div (shared by both divisions) and omv_mul
//
//  channel | direction | signals                                          | request
//  in      | input     | in_valid, in_ready, sample                       | one sample
//  out     | output    | out_valid, out_ready, sample_count, running_mean,| one result
//          |           | squared_dev_sum, variance                        |
//
// a result shows after the mean division, the multiply and the variance division, and the next
// request can be taken once it shows; the mean division runs SAMPLE_WIDTH+1 steps, the multiply
// SAMPLE_WIDTH steps, the variance division 63 steps (skipped at count one)
// reset clears count, mean and sum to zero and empties the output register
// a new request is taken while the previous result waits in the output register;
// a stalled output holds the finished result in the last step until the register frees

module online_mean_variance_core #(
	parameter int SAMPLE_WIDTH = omv_pkg::SAMPLE_WIDTH_DEF,
	parameter int COUNT_WIDTH  = omv_pkg::COUNT_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [omv_pkg::IO_W-1:0] sample,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [omv_pkg::IO_W-1:0]      sample_count,
	output logic signed [omv_pkg::IO_W-1:0] running_mean,
	output logic [omv_pkg::SUM_W-1:0]     squared_dev_sum,
	output logic [omv_pkg::SUM_W-1:0]     variance
);

	localparam int SW   = SAMPLE_WIDTH;
	localparam int CW   = COUNT_WIDTH;
	localparam int SUMW = omv_pkg::SUM_W;
	localparam int IOW  = omv_pkg::IO_W;
	localparam int CNTW = omv_pkg::DIV_CNT_W;

	omv_pkg::omv_state_t state_q, state_d;

	logic [CW-1:0]        count_q;
	logic signed [SW-1:0] mean_q;
	logic [SUMW-1:0]      sum_q;
	logic signed [SW-1:0] x_q;
	logic [SW-1:0]        dmag_q;
	logic                 dneg_q;
	logic [SW-1:0]        rmag_q;
	logic [SUMW-1:0]      var_q;

	logic                 out_valid_q;
	logic [IOW-1:0]       sample_count_q;
	logic signed [IOW-1:0] running_mean_q;
	logic [SUMW-1:0]      squared_dev_sum_q;
	logic [SUMW-1:0]      variance_q;

	logic                 accept;
	logic signed [SW-1:0] x_in;
	logic signed [SW:0]   delta_in;
	logic signed [SW:0]   dabs_in;
	logic [CW-1:0]        count_next;
	logic signed [SW:0]   resid;
	logic signed [SW:0]   rabs;
	logic [SW:0]          q_mean;
	logic signed [SW+1:0] mean_new;
	logic [SUMW+1:0]      sum_ext;
	logic                 count_gt1;
	logic [IOW-1:0]       cnt_out;
	logic                 out_free;

	logic                 div_start;
	logic                 div_var;
	logic [CNTW-1:0]      div_iters;
	logic [SUMW-1:0]      div_dividend;
	logic [SUMW-1:0]      div_quotient;
	omv_pkg::omv_unit_stat_t div_stat;

	logic                 mul_start;
	logic [2*SW-1:0]      mul_prod;
	omv_pkg::omv_unit_stat_t mul_stat;

	assign accept   = in_valid & in_ready;
	assign out_free = ~out_valid_q | out_ready;

	always_comb begin
		x_in       = signed'(sample[SW-1:0]);
		delta_in   = (SW+1)'(x_in) - (SW+1)'(mean_q);
		dabs_in    = delta_in[SW] ? -delta_in : delta_in;
		count_next = (count_q == {CW{1'b1}}) ? count_q : count_q + 1'b1;
		resid      = (SW+1)'(x_q) - (SW+1)'(mean_q);
		rabs       = resid[SW] ? -resid : resid;
		q_mean     = div_quotient[SW:0];
		mean_new   = dneg_q ? (SW+2)'(mean_q) - (SW+2)'({1'b0, q_mean})
		                    : (SW+2)'(mean_q) + (SW+2)'({1'b0, q_mean});
		sum_ext    = {2'b00, sum_q} + (SUMW+2)'(mul_prod);
		count_gt1  = count_q > CW'(1);
	end

	generate
		if (CW > IOW) begin : g_cnt_clamp
			assign cnt_out = (|count_q[CW-1:IOW]) ? {IOW{1'b1}} : count_q[IOW-1:0];
		end else begin : g_cnt_ext
			assign cnt_out = IOW'(count_q);
		end
	endgenerate

	// divider operand select: mean step in the top bits, or the whole sum
	always_comb begin
		div_dividend = div_var ? sum_q
		                       : (SUMW'(dabs_in[SW-1:0]) << (SUMW - SW - 1));
		div_iters    = div_var ? CNTW'(SUMW) : CNTW'(SW + 1);
	end

	omv_div #(
		.COUNT_WIDTH(CW)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.iters    (div_iters),
		.dividend (div_dividend),
		.divisor  (div_var ? count_q : count_next),
		.quotient (div_quotient),
		.stat     (div_stat)
	);

	omv_mul #(
		.SAMPLE_WIDTH(SW)
	) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mul_start),
		.mcand  (dmag_q),
		.mplier (rmag_q),
		.prod   (mul_prod),
		.stat   (mul_stat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= omv_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		div_start = 1'b0;
		div_var   = 1'b0;
		mul_start = 1'b0;
		case (state_q)
			omv_pkg::ST_IDLE: begin
				in_ready  = 1'b1;
				div_start = in_valid;
				if (in_valid) begin
					state_d = omv_pkg::ST_DIV_MEAN;
				end
			end
			omv_pkg::ST_DIV_MEAN: begin
				if (div_stat.done) begin
					state_d = omv_pkg::ST_RESID;
				end
			end
			omv_pkg::ST_RESID: begin
				state_d = omv_pkg::ST_MUL;
			end
			omv_pkg::ST_MUL: begin
				mul_start = ~mul_stat.busy & ~mul_stat.done;
				if (mul_stat.done) begin
					state_d = omv_pkg::ST_ACC;
				end
			end
			omv_pkg::ST_ACC: begin
				state_d = omv_pkg::ST_VAR;
			end
			omv_pkg::ST_VAR: begin
				div_var   = 1'b1;
				div_start = count_gt1;
				state_d   = count_gt1 ? omv_pkg::ST_DIV_VAR : omv_pkg::ST_DONE;
			end
			omv_pkg::ST_DIV_VAR: begin
				div_var = 1'b1;
				if (div_stat.done) begin
					state_d = omv_pkg::ST_DONE;
				end
			end
			omv_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = omv_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = omv_pkg::ST_IDLE;
			end
		endcase
	end

	// running statistics
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			mean_q  <= '0;
			sum_q   <= '0;
		end else begin
			if (accept) begin
				count_q <= count_next;
			end
			if (state_q == omv_pkg::ST_DIV_MEAN && div_stat.done) begin
				mean_q <= mean_new[SW-1:0];
			end
			if (state_q == omv_pkg::ST_ACC) begin
				sum_q <= (|sum_ext[SUMW+1:SUMW]) ? {SUMW{1'b1}} : sum_ext[SUMW-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			x_q    <= x_in;
			dmag_q <= dabs_in[SW-1:0];
			dneg_q <= delta_in[SW];
		end
		if (state_q == omv_pkg::ST_RESID) begin
			rmag_q <= rabs[SW-1:0];
		end
		if (state_q == omv_pkg::ST_VAR) begin
			var_q <= '0;
		end else if (state_q == omv_pkg::ST_DIV_VAR && div_stat.done) begin
			var_q <= div_quotient;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == omv_pkg::ST_DONE && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == omv_pkg::ST_DONE && out_free) begin
			sample_count_q    <= cnt_out;
			running_mean_q    <= IOW'(mean_q);
			squared_dev_sum_q <= sum_q;
			variance_q        <= var_q;
		end
	end

	assign out_valid       = out_valid_q;
	assign sample_count    = sample_count_q;
	assign running_mean    = running_mean_q;
	assign squared_dev_sum = squared_dev_sum_q;
	assign variance        = variance_q;

endmodule

/* src/omv_checker.sv */
// omv_checker: port-level assertions for online_mean_variance_core
// bound to the top level below; depends on omv_pkg

module omv_checker (
	input logic                             clk,
	input logic                             arst_n,
	input logic                             in_valid,
	input logic                             in_ready,
	input logic signed [omv_pkg::IO_W-1:0]  sample,
	input logic                             out_valid,
	input logic                             out_ready,
	input logic [omv_pkg::IO_W-1:0]         sample_count,
	input logic signed [omv_pkg::IO_W-1:0]  running_mean,
	input logic [omv_pkg::SUM_W-1:0]        squared_dev_sum,
	input logic [omv_pkg::SUM_W-1:0]        variance
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(sample_count)
			&& $stable(running_mean) && $stable(squared_dev_sum) && $stable(variance))
		else $error("output changed while stalled");

	// one request in flight
	a_busy_after_req: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken again right after a request");

	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> sample_count != '0)
		else $error("result with zero sample count");

	a_var_first: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && sample_count <= omv_pkg::IO_W'(1) |-> variance == '0)
		else $error("nonzero variance for a single sample");

	a_var_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> variance <= squared_dev_sum)
		else $error("variance above squared deviation sum");

endmodule

bind online_mean_variance_core omv_checker u_omv_checker (.*);
